// File: src/drs_pkg.sv
// ---------------------------------------------------------------------------
// Disk request scheduler package
// Shared sizes, codes and record types for the scheduler and its cells.
// ---------------------------------------------------------------------------
package drs_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int TRK_W       = 16;
   localparam int MODE_W      = 3;

   localparam logic [MODE_W-1:0] MODE_FIFO  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLOOK = 3'd4;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_PICK = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [TRK_W-1:0] track;
      logic             act;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic set_act;
   } cell_ctl_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [ID_W-1:0]  id;
      logic [TRK_W-1:0] track;
   } best_type;

   typedef struct packed {
      logic start;
      logic en;
      logic active_only;
   } scan_ctl_type;

   typedef struct packed {
      logic             add_accepted;
      logic             grant_found;
      logic [ID_W-1:0]  grant_id;
      logic [TRK_W-1:0] grant_track;
   } result_type;

endpackage

// File: src/drs_if.sv
// ---------------------------------------------------------------------------
// Disk request scheduler channels
// Request, response and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
interface drs_req_if import drs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [ID_W-1:0]  req_id;
   logic [TRK_W-1:0] req_track;
   logic [TRK_W-1:0] head_track;
   modport source (output valid, req_type, req_id, req_track, head_track, input ready);
   modport sink   (input valid, req_type, req_id, req_track, head_track, output ready);
endinterface

interface drs_rsp_if import drs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             add_accepted;
   logic             grant_found;
   logic [ID_W-1:0]  grant_id;
   logic [TRK_W-1:0] grant_track;
   modport source (output valid, add_accepted, grant_found, grant_id, grant_track,
                   input ready);
   modport sink   (input valid, add_accepted, grant_found, grant_id, grant_track,
                   output ready);
endinterface

interface drs_csr_if import drs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] policy_mode;
   modport source (output valid, policy_mode, input ready);
   modport sink   (input valid, policy_mode, output ready);
endinterface

// File: src/drs_cell.sv
// ---------------------------------------------------------------------------
// Queue cell
// Holds one queued request and takes its neighbor's entry when told to.
// ---------------------------------------------------------------------------
module drs_cell
   import drs_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    load_data,
   input  entry_type    next_data,
   output entry_type    cur_data
);

   entry_type ent_ff;
   entry_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      if (ctl.load) begin
         ent_in = load_data;
      end else if (ctl.shift) begin
         ent_in = next_data;
      end else if (ctl.set_act) begin
         ent_in.act = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign cur_data = ent_ff;

endmodule

// File: src/drs_scan.sv
// ---------------------------------------------------------------------------
// Scan unit
// Watches the entry at the front of the rotating queue and keeps the best
// candidate for each policy: upward, downward, nearest and lowest track.
// ---------------------------------------------------------------------------
module drs_scan
   import drs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  scan_ctl_type     ctl,
   input  logic [TRK_W-1:0] head,
   input  logic [IDX_W-1:0] idx,
   input  entry_type        ent,
   output best_type         up_best,
   output best_type         down_best,
   output best_type         near_best,
   output best_type         low_best
);

   best_type up_ff, down_ff, near_ff, low_ff;
   best_type up_in, down_in, near_in, low_in;
   best_type cand;
   logic             elig;
   logic [TRK_W-1:0] dist_new, dist_old;

   always_comb begin
      cand.found = 1'b1;
      cand.idx   = idx;
      cand.id    = ent.id;
      cand.track = ent.track;
      elig = !ctl.active_only || ent.act;
      dist_new = (ent.track >= head) ? ent.track - head : head - ent.track;
      dist_old = (near_ff.track >= head) ? near_ff.track - head : head - near_ff.track;
      up_in = up_ff;
      down_in = down_ff;
      near_in = near_ff;
      low_in = low_ff;
      if (ctl.start) begin
         up_in.found   = 1'b0;
         down_in.found = 1'b0;
         near_in.found = 1'b0;
         low_in.found  = 1'b0;
      end else if (ctl.en) begin
         // Strict compares keep the oldest entry on a tie.
         if (elig && ent.track >= head && (!up_ff.found || ent.track < up_ff.track)) begin
            up_in = cand;
         end
         if (elig && ent.track <= head &&
             (!down_ff.found || ent.track > down_ff.track)) begin
            down_in = cand;
         end
         if (!near_ff.found || dist_new < dist_old) begin
            near_in = cand;
         end
         if (!low_ff.found || ent.track < low_ff.track) begin
            low_in = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff.found   <= 1'b0;
         down_ff.found <= 1'b0;
         near_ff.found <= 1'b0;
         low_ff.found  <= 1'b0;
      end else begin
         up_ff.found   <= up_in.found;
         down_ff.found <= down_in.found;
         near_ff.found <= near_in.found;
         low_ff.found  <= low_in.found;
      end
      up_ff.idx     <= up_in.idx;
      up_ff.id      <= up_in.id;
      up_ff.track   <= up_in.track;
      down_ff.idx   <= down_in.idx;
      down_ff.id    <= down_in.id;
      down_ff.track <= down_in.track;
      near_ff.idx   <= near_in.idx;
      near_ff.id    <= near_in.id;
      near_ff.track <= near_in.track;
      low_ff.idx    <= low_in.idx;
      low_ff.id     <= low_in.id;
      low_ff.track  <= low_in.track;
   end

   assign up_best   = up_ff;
   assign down_best = down_ff;
   assign near_best = near_ff;
   assign low_best  = low_ff;

endmodule

// File: src/disk_request_scheduler.sv
// ---------------------------------------------------------------------------
// Disk request scheduler
// Queue of pending disk requests with fifo, shortest seek, look, circular
// look and frozen look selection.
//
//   channel   dir   carries
//   req_if    in    add or pick request, id, track, head position
//   rsp_if    out   add status, grant flag, granted id and track
//   csr_if    in    policy mode
//
// An add, a fifo pick and a pick on an empty queue pass through the output
// state to the response register. Other picks rotate the whole ring of
// QUEUE_DEPTH cells past the scan unit once, then close the gap.
// One request is in flight at a time; a stalled response holds the next.
// Reset is synchronous and empties the queue, sweep starts upward.
// ---------------------------------------------------------------------------
module disk_request_scheduler
   import drs_pkg::*;
(
   input logic      clock,
   input logic      reset,
   drs_req_if.sink  req_if,
   drs_rsp_if.source rsp_if,
   drs_csr_if.sink  csr_if
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_OUT    = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              sweep_ff, sweep_in;
   logic [MODE_W-1:0] mode_ff;
   logic [TRK_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   result_type        res_ff, res_in;
   logic              rsp_valid_ff;
   result_type        rsp_ff;

   entry_type    cell_q [QUEUE_DEPTH];
   cell_ctl_type cell_ctl [QUEUE_DEPTH];
   entry_type    load_ent;
   logic [QUEUE_DEPTH-1:0] act_vec;
   logic         any_active;
   logic         accept, is_add, is_pick, out_free, full, fifo_like;
   logic         rotate, compact;
   logic [IDX_W-1:0] sel_idx;
   best_type     up_best, down_best, near_best, low_best, chosen;
   scan_ctl_type scan_ctl;

   assign accept   = req_if.valid && req_if.ready;
   assign is_add   = req_if.req_type == REQ_ADD;
   assign is_pick  = req_if.req_type == REQ_PICK;
   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign fifo_like = !(mode_ff == MODE_SSTF || mode_ff == MODE_LOOK ||
                        mode_ff == MODE_CLOOK || mode_ff == MODE_FLOOK);
   assign req_if.ready = state_ff == ST_IDLE;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIFO;
      end else if (csr_if.valid) begin
         mode_ff <= csr_if.policy_mode;
      end
   end

   always_comb begin
      load_ent.id    = req_if.req_id;
      load_ent.track = req_if.req_track;
      load_ent.act   = 1'b0;
   end

   // Decision after a full scan.
   always_comb begin
      chosen   = near_best;
      sweep_in = sweep_ff;
      if (mode_ff == MODE_LOOK || mode_ff == MODE_FLOOK) begin
         if (sweep_ff) begin
            chosen = up_best;
            if (!up_best.found) begin
               sweep_in = 1'b0;
               chosen   = down_best;
            end
         end else begin
            chosen = down_best;
            if (!down_best.found) begin
               sweep_in = 1'b1;
               chosen   = up_best;
            end
         end
      end else if (mode_ff == MODE_CLOOK) begin
         chosen = up_best.found ? up_best : low_best;
      end
      if (state_ff != ST_DECIDE) begin
         sweep_in = sweep_ff;
      end
   end

   always_comb begin
      any_active = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         act_vec[i] = cell_q[i].act && (CNT_W'(i) < count_ff);
      end
      any_active = |act_vec;
   end

   assign rotate  = state_ff == ST_SCAN;
   assign compact = (state_ff == ST_DECIDE && chosen.found) ||
                    (state_ff == ST_IDLE && accept && is_pick && fifo_like &&
                     count_ff != '0);
   assign sel_idx = (state_ff == ST_DECIDE) ? chosen.idx : '0;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_ctl[i].load    = accept && is_add && !full && CNT_W'(i) == count_ff;
         cell_ctl[i].shift   = rotate || (compact && IDX_W'(i) >= sel_idx);
         cell_ctl[i].set_act = accept && is_pick && mode_ff == MODE_FLOOK && !any_active;
      end
   end

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      drs_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[g]),
         .load_data (load_ent),
         .next_data (cell_q[(g + 1) % QUEUE_DEPTH]),
         .cur_data  (cell_q[g])
      );
   end

   always_comb begin
      scan_ctl.start       = accept;
      scan_ctl.en          = state_ff == ST_SCAN && CNT_W'(step_ff) < count_ff;
      scan_ctl.active_only = mode_ff == MODE_FLOOK;
   end

   drs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .head      (head_ff),
      .idx       (step_ff),
      .ent       (cell_q[0]),
      .up_best   (up_best),
      .down_best (down_best),
      .near_best (near_best),
      .low_best  (low_best)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      head_in  = head_ff;
      step_in  = step_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in  = '0;
               head_in = req_if.head_track;
               step_in = '0;
               state_in = ST_OUT;
               if (is_add) begin
                  if (!full) begin
                     res_in.add_accepted = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff != '0) begin
                  if (fifo_like) begin
                     res_in.grant_found = 1'b1;
                     res_in.grant_id    = cell_q[0].id;
                     res_in.grant_track = cell_q[0].track;
                     count_in = count_ff - 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_in = '0;
            if (chosen.found) begin
               res_in.grant_found = 1'b1;
               res_in.grant_id    = chosen.id;
               res_in.grant_track = chosen.track;
               count_in = count_ff - 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sweep_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      head_ff <= head_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      if (state_ff == ST_OUT && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.add_accepted = rsp_ff.add_accepted;
   assign rsp_if.grant_found  = rsp_ff.grant_found;
   assign rsp_if.grant_id     = rsp_ff.grant_id;
   assign rsp_if.grant_track  = rsp_ff.grant_track;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request accepted but scheduler stayed idle");

   a_decide_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> chosen.found)
      else $error("scan of a non-empty queue found no request");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && is_add && !full) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("stored add did not grow the queue");
`endif

endmodule
